// File: rtl/chp_pkg.sv
package chp_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int NUM_W   = IDX_W + 1;
    localparam int CNT_W   = 5;
    localparam int COORD_W = 32;
    localparam int DELTA_W = 17;
    localparam int PROG_W  = 16;
    localparam int SEG_W   = 4;
    localparam int LOAD_W  = 4;

    localparam logic [CNT_W-1:0] POINT_COUNT_RESET = CNT_W'(4);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [LOAD_W-1:0]         load_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [DELTA_W-1:0]        delta;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [PROG_W-1:0]         progress;
        logic [SEG_W-1:0]          segment_index;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

endpackage

// File: rtl/chp_point_ram.sv
module chp_point_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [chp_pkg::IDX_W-1:0]   i_waddr,
    input  chp_pkg::t_point             i_wdata,
    input  chp_pkg::t_rd_req            i_rd,
    output chp_pkg::t_point             o_rdata
);

    chp_pkg::t_point r_mem [chp_pkg::MAX_POINTS];
    chp_pkg::t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/chp_engine.sv
module chp_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [chp_pkg::DELTA_W-1:0]   i_delta,
    input  logic [chp_pkg::CNT_W-1:0]     i_point_count,
    input  logic                          i_res_ready,
    input  chp_pkg::t_point               i_rd_data,
    output chp_pkg::t_rd_req              o_rd,
    output logic                          o_busy,
    output logic                          o_res_valid,
    output chp_pkg::t_out_item            o_res
);

    localparam int IDX_W   = chp_pkg::IDX_W;
    localparam int NUM_W   = chp_pkg::NUM_W;
    localparam int F       = chp_pkg::FRAC_BITS;
    localparam int H_W     = F + 3;
    localparam int HC_W    = H_W + 1;
    localparam int PROD_W  = H_W + chp_pkg::COORD_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int SH_W    = ACC_W - F;
    localparam int SUM_W   = chp_pkg::DELTA_W + 1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] LAST_PT = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_ADV, S_SQ, S_CUBE, S_BASIS, S_MAC, S_DRAIN, S_FIN
    } t_state;

    t_state                     r_state;
    logic [F-1:0]               r_progress;
    logic [IDX_W-1:0]           r_start;
    logic [chp_pkg::DELTA_W-1:0] r_delta;
    logic [F-1:0]               r_t2;
    logic signed [H_W-1:0]      r_h   [4];
    logic [IDX_W-1:0]           r_idx [4];
    logic [1:0]                 r_k;
    logic [1:0]                 r_ax;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_pvalid;
    logic [1:0]                 r_pax;
    logic signed [ACC_W-1:0]    r_acc [3];

    logic [NUM_W-1:0]           w_n;
    logic [IDX_W-1:0]           w_s0;
    logic [SUM_W-1:0]           w_sum;
    logic                       w_wrap;
    logic [IDX_W-1:0]           w_s;
    logic [IDX_W-1:0]           w_e;
    logic [IDX_W-1:0]           w_p;
    logic [IDX_W-1:0]           w_a;
    logic signed [H_W-1:0]      w_mul_a;
    logic signed [chp_pkg::COORD_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [HC_W-1:0]     w_t;
    logic signed [HC_W-1:0]     w_t2;
    logic signed [HC_W-1:0]     w_t3;
    logic signed [HC_W-1:0]     w_one;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                  input logic [NUM_W-1:0] n);
        logic [NUM_W-1:0] nx;
        nx = {1'b0, x} + NUM_W'(1);
        return (nx >= n) ? '0 : nx[IDX_W-1:0];
    endfunction

    function automatic logic signed [chp_pkg::COORD_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        logic signed [SH_W-1:0]  sh;
        logic signed [SH_W-1:0]  hi;
        logic signed [SH_W-1:0]  lo;
        rnd = acc + ACC_W'(1 << (F - 1));
        sh  = SH_W'(rnd >>> F);
        hi  = SH_W'(32'sh7fffffff);
        lo  = SH_W'(-32'sh7fffffff - 1);
        if (sh > hi) begin
            return 32'sh7fffffff;
        end else if (sh < lo) begin
            return -32'sh7fffffff - 1;
        end
        return sh[chp_pkg::COORD_W-1:0];
    endfunction

    always_comb begin
        if (i_point_count == '0) begin
            w_n = NUM_W'(1);
        end else if (32'(i_point_count) > chp_pkg::MAX_POINTS) begin
            w_n = NUM_W'(chp_pkg::MAX_POINTS);
        end else begin
            w_n = NUM_W'(i_point_count);
        end
        w_s0   = ({1'b0, r_start} >= w_n) ? '0 : r_start;
        w_sum  = SUM_W'(r_progress) + SUM_W'(r_delta);
        w_wrap = w_sum >= SUM_W'(1 << F);
        w_s    = w_wrap ? wrap_inc(w_s0, w_n) : w_s0;
        w_e    = wrap_inc(w_s, w_n);
        w_a    = wrap_inc(w_e, w_n);
        w_p    = (w_s == '0) ? IDX_W'(w_n - NUM_W'(1)) : w_s - IDX_W'(1);
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQ: begin
                w_mul_a = $signed({{(H_W - F){1'b0}}, r_progress});
                w_mul_b = $signed({{(chp_pkg::COORD_W - F){1'b0}}, r_progress});
            end
            S_CUBE: begin
                w_mul_a = $signed({{(H_W - F){1'b0}}, r_prod[2*F-1:F]});
                w_mul_b = $signed({{(chp_pkg::COORD_W - F){1'b0}}, r_progress});
            end
            S_MAC: begin
                w_mul_a = r_h[r_k];
                case (r_ax)
                    AX_X:    w_mul_b = i_rd_data.x;
                    AX_Y:    w_mul_b = i_rd_data.y;
                    default: w_mul_b = i_rd_data.z;
                endcase
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    end

    always_comb begin
        w_t   = $signed({{(HC_W - F){1'b0}}, r_progress});
        w_t2  = $signed({{(HC_W - F){1'b0}}, r_t2});
        w_t3  = $signed({{(HC_W - F){1'b0}}, r_prod[2*F-1:F]});
        w_one = HC_W'(1 << F);
    end

    always_comb begin
        o_rd.en   = 1'b0;
        o_rd.addr = r_idx[0];
        if (r_state == S_BASIS) begin
            o_rd.en = 1'b1;
        end else if (r_state == S_MAC && r_ax == AX_Z && r_k != LAST_PT) begin
            o_rd.en   = 1'b1;
            o_rd.addr = r_idx[2'(r_k + 2'd1)];
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = (r_state == S_FIN) && i_res_ready;

    always_comb begin
        o_res.pos_x         = round_sat(r_acc[0]);
        o_res.pos_y         = round_sat(r_acc[1]);
        o_res.pos_z         = round_sat(r_acc[2]);
        o_res.progress      = r_progress;
        o_res.segment_index = chp_pkg::SEG_W'(r_start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_progress <= '0;
            r_start    <= '0;
            r_k        <= '0;
            r_ax       <= '0;
            r_pvalid   <= 1'b0;
        end else begin
            r_pvalid <= r_state == S_MAC;
            r_pax    <= r_ax;
            if (r_pvalid) begin
                r_acc[r_pax] <= r_acc[r_pax] + ACC_W'(r_prod);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_delta <= i_delta;
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_progress <= w_wrap ? '0 : w_sum[F-1:0];
                    r_start    <= w_s;
                    r_idx[0]   <= w_s;
                    r_idx[1]   <= w_e;
                    r_idx[2]   <= w_p;
                    r_idx[3]   <= w_a;
                    r_state    <= S_SQ;
                end
                S_SQ: begin
                    r_prod  <= w_prod;
                    r_state <= S_CUBE;
                end
                S_CUBE: begin
                    r_t2    <= r_prod[2*F-1:F];
                    r_prod  <= w_prod;
                    r_state <= S_BASIS;
                end
                S_BASIS: begin
                    r_h[0]   <= H_W'(w_t3 + w_t3 - (w_t2 + w_t2 + w_t2) + w_one);
                    r_h[1]   <= H_W'(w_t2 + w_t2 + w_t2 - (w_t3 + w_t3));
                    r_h[2]   <= H_W'(w_t3 - (w_t2 + w_t2) + w_t);
                    r_h[3]   <= H_W'(w_t3 - w_t2);
                    r_acc[0] <= '0;
                    r_acc[1] <= '0;
                    r_acc[2] <= '0;
                    r_k      <= '0;
                    r_ax     <= AX_X;
                    r_state  <= S_MAC;
                end
                S_MAC: begin
                    r_prod <= w_prod;
                    if (r_ax == AX_Z) begin
                        r_ax <= AX_X;
                        r_k  <= r_k + 2'd1;
                        if (r_k == LAST_PT) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/closed_loop_hermite_path_follower_top.sv
// Closed-loop cubic Hermite path follower.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): a load
// transaction writes one control point into the point memory and gives no
// result; a tick transaction advances progress by delta, steps the segment
// index round the loop when progress reaches 1.0, and gives one result.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): position
// saturated to Q16.16 per axis, progress and segment index after the tick.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data): point count,
// always ready; write it only while the block is idle.
// A load is written when accepted and does not stall the input. A tick
// steps through advance, square, cube, basis, multiply-accumulate, drain
// and finish states, and no new transaction is taken until it is done:
// one shared 19x32 multiplier forms t^2, t^3 and then the twelve
// basis-by-coordinate products, fed by a one-read-port point memory read
// four times. The input is stalled while a tick is in progress.
// A finished result sits in the output register; the next transaction is
// taken while it waits, and a later tick holds in its last step until the
// receiver has taken the earlier result.
// Reset clears progress and segment index to zero and the point count to 4;
// point memory contents are undefined until loaded.
module closed_loop_hermite_path_follower_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  chp_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output chp_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [chp_pkg::CNT_W-1:0]     i_cfg_data
);

    logic [chp_pkg::CNT_W-1:0] r_point_count;
    logic                      r_out_valid;
    chp_pkg::t_out_item        r_out_data;

    logic                      w_in_accept;
    logic                      w_mem_we;
    logic                      w_start;
    logic                      w_busy;
    logic                      w_res_ready;
    logic                      w_res_valid;
    chp_pkg::t_out_item        w_res;
    chp_pkg::t_point           w_wdata;
    chp_pkg::t_point           w_rdata;
    chp_pkg::t_rd_req          w_rd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_mem_we    = w_in_accept && (i_in_data.kind == chp_pkg::KIND_LOAD)
                         && (32'(i_in_data.load_index) < chp_pkg::MAX_POINTS);
    assign w_start     = w_in_accept && (i_in_data.kind == chp_pkg::KIND_TICK);
    assign w_res_ready = !r_out_valid || !i_out_stall;

    assign w_wdata.x = i_in_data.point_x;
    assign w_wdata.y = i_in_data.point_y;
    assign w_wdata.z = i_in_data.point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= chp_pkg::POINT_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_point_count <= i_cfg_data;
        end
    end

    chp_point_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (chp_pkg::IDX_W'(i_in_data.load_index)),
        .i_wdata (w_wdata),
        .i_rd    (w_rd),
        .o_rdata (w_rdata)
    );

    chp_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_delta       (i_in_data.delta),
        .i_point_count (r_point_count),
        .i_res_ready   (w_res_ready),
        .i_rd_data     (w_rdata),
        .o_rd          (w_rd),
        .o_busy        (w_busy),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrites a pending transaction");

    a_tick_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> o_in_stall)
        else $error("input not stalled after tick");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_rd.en))
        else $error("point write and read in the same cycle");

    a_res_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_busy)
        else $error("result outside a tick");

endmodule
